/* rtl/core/rsr_pkg.sv */
// Shared types and codes for the ring shortest route counter.
package rsr_pkg;

    // Node index width, fixed by the request and result fields
    localparam int NODE_W = 6;
    // Width of the ring size register
    localparam int RING_W = 7;
    // Smallest usable ring
    localparam logic [RING_W-1:0] MIN_RING = 7'd2;
    // Depth of the command queue between front and back
    localparam int CMD_DEPTH = 2;

    // Request type codes
    localparam logic REQ_ROUTE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // Result kind codes
    localparam logic [2:0] KIND_SENT      = 3'd0;
    localparam logic [2:0] KIND_FORWARDED = 3'd1;
    localparam logic [2:0] KIND_DELIVERED = 3'd2;
    localparam logic [2:0] KIND_READOUT   = 3'd3;
    localparam logic [2:0] KIND_ERROR     = 3'd4;

    // Request transaction
    typedef struct packed {
        logic              req_type;
        logic [NODE_W-1:0] source_node;
        logic [NODE_W-1:0] target_node;
        logic [NODE_W-1:0] query_node;
    } in_t;

    // Result transaction
    typedef struct packed {
        logic [2:0]        kind;
        logic [NODE_W-1:0] at_node;
        logic [NODE_W-1:0] from_node;
        logic [NODE_W-1:0] next_node;
        logic              going_right;
        logic [31:0]       created_total;
        logic [31:0]       delivered_total;
        logic [31:0]       forwarded_total;
        logic              last;
    } out_t;

    // Classified command passed from front to back
    typedef enum logic [1:0] {
        OP_ERR,
        OP_READ,
        OP_ROUTE
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t           op;
        logic [NODE_W-1:0] a_node;   // source, or query node
        logic [NODE_W-1:0] b_node;   // target, or query node
        logic              right;
    } cmd_t;

    // Counter bank control from the back end
    typedef struct packed {
        logic [NODE_W-1:0] cr_addr;
        logic [NODE_W-1:0] dl_addr;
        logic [NODE_W-1:0] fw_addr;
        logic              cr_inc;
        logic              dl_inc;
        logic              fw_inc;
    } bank_ctl_t;

endpackage

/* rtl/core/rsr_front.sv */
// Front end: ring size register, request check and direction choice.
module rsr_front #(
    parameter int MAX_NODES = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  rsr_pkg::in_t                 req,
    input  logic                         cfg_wr_en,
    input  logic [rsr_pkg::RING_W-1:0]   cfg_wr_data,
    input  logic                         fifo_full,
    output logic                         push,
    output rsr_pkg::cmd_t                push_cmd,
    output logic [rsr_pkg::RING_W-1:0]   ring_size
);
    import rsr_pkg::*;

    logic [RING_W-1:0] node_count_reg;
    logic [RING_W-1:0] src7;
    logic [RING_W-1:0] dst7;
    logic [RING_W-1:0] qry7;
    logic [RING_W-1:0] dist_right;
    logic              go_right;

    // Ring size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= 7'd4;
        end
        else if (cfg_wr_en)
        begin
            node_count_reg <= cfg_wr_data;
        end
    end

    // Clamp ring size to the usable range
    always_comb
    begin
        if (node_count_reg < MIN_RING)
        begin
            ring_size = MIN_RING;
        end
        else if (node_count_reg > RING_W'(MAX_NODES))
        begin
            ring_size = RING_W'(MAX_NODES);
        end
        else
        begin
            ring_size = node_count_reg;
        end
    end

    assign busy = fifo_full;
    assign push = start && !fifo_full;

    assign src7 = {1'b0, req.source_node};
    assign dst7 = {1'b0, req.target_node};
    assign qry7 = {1'b0, req.query_node};

    // Rightward distance; go right when it is no more than half the ring
    assign dist_right = (dst7 >= src7) ? (dst7 - src7) : (dst7 + ring_size - src7);
    assign go_right   = (src7 != dst7) &&
                        (({1'b0, dist_right} << 1) <= {1'b0, ring_size});

    // Classify the request
    always_comb
    begin
        push_cmd.right = 1'b0;
        if (req.req_type == REQ_READ)
        begin
            push_cmd.op     = (qry7 >= ring_size) ? OP_ERR : OP_READ;
            push_cmd.a_node = req.query_node;
            push_cmd.b_node = req.query_node;
        end
        else
        begin
            push_cmd.a_node = req.source_node;
            push_cmd.b_node = req.target_node;
            if (src7 >= ring_size || dst7 >= ring_size)
            begin
                push_cmd.op = OP_ERR;
            end
            else
            begin
                push_cmd.op    = OP_ROUTE;
                push_cmd.right = go_right;
            end
        end
    end

endmodule

/* rtl/core/rsr_cmd_fifo.sv */
// Short command queue between the front and back ends.
module rsr_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rsr_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          empty,
    output rsr_pkg::cmd_t head
);
    import rsr_pkg::*;

    localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    cmd_t             entry_reg [CMD_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(CMD_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/rsr_counter_bank.sv */
// Per-node created, delivered and forwarded counters with saturating update.
module rsr_counter_bank #(
    parameter int MAX_NODES   = 64,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rsr_pkg::bank_ctl_t     ctl,
    output logic [COUNT_WIDTH-1:0] created,
    output logic [COUNT_WIDTH-1:0] delivered,
    output logic [COUNT_WIDTH-1:0] forwarded
);
    import rsr_pkg::*;

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    logic [NODE_W-1:0]      addr [3];
    logic                   inc  [3];
    logic [COUNT_WIDTH-1:0] cnt  [3];

    assign addr[0] = ctl.cr_addr;
    assign addr[1] = ctl.dl_addr;
    assign addr[2] = ctl.fw_addr;
    assign inc[0]  = ctl.cr_inc;
    assign inc[1]  = ctl.dl_inc;
    assign inc[2]  = ctl.fw_inc;

    assign created   = cnt[0];
    assign delivered = cnt[1];
    assign forwarded = cnt[2];

    // One counter memory per count type; increment goes to the last read address
    for (genvar g = 0; g < 3; g++)
    begin : g_bank
        logic [COUNT_WIDTH-1:0] cnt_mem [MAX_NODES];
        logic [MAX_NODES-1:0]   vld_reg;
        logic [AW-1:0]          raddr_reg;
        logic [COUNT_WIDTH-1:0] rdata_reg;
        logic                   rvld_reg;
        logic [AW-1:0]          rd_addr;
        logic [COUNT_WIDTH-1:0] inc_val;

        assign rd_addr = addr[g][AW-1:0];
        // never written entries read as zero
        assign cnt[g]  = rvld_reg ? rdata_reg : '0;
        assign inc_val = (&cnt[g]) ? cnt[g] : cnt[g] + COUNT_WIDTH'(1);

        // Memory read and write
        always_ff @(posedge clk)
        begin
            rdata_reg <= cnt_mem[rd_addr];
            raddr_reg <= rd_addr;
            if (inc[g])
            begin
                cnt_mem[raddr_reg] <= inc_val;
            end
        end

        // Entry valid bits
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg  <= '0;
                rvld_reg <= 1'b0;
            end
            else
            begin
                rvld_reg <= vld_reg[rd_addr];
                if (inc[g])
                begin
                    vld_reg[raddr_reg] <= 1'b1;
                end
            end
        end
    end

endmodule

/* rtl/core/rsr_back.sv */
// Back end: walks the ring hop by hop, drives counter updates and results.
module rsr_back #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         empty,
    input  rsr_pkg::cmd_t                head,
    output logic                         pop,
    input  logic [rsr_pkg::RING_W-1:0]   ring_size,
    output rsr_pkg::bank_ctl_t           bank_ctl,
    input  logic [COUNT_WIDTH-1:0]       created,
    input  logic [COUNT_WIDTH-1:0]       delivered,
    input  logic [COUNT_WIDTH-1:0]       forwarded,
    output rsr_pkg::out_t                result,
    output logic                         strobe
);
    import rsr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READOUT,
        ST_FIRST,
        ST_WALK
    } state_t;

    state_t            state_reg,   state_next;
    logic [NODE_W-1:0] a_reg,       a_next;
    logic [NODE_W-1:0] b_reg,       b_next;
    logic [NODE_W-1:0] cur_reg,     cur_next;
    logic [NODE_W-1:0] prev_reg,    prev_next;
    logic              right_reg,   right_next;
    logic              fw_pend_reg, fw_pend_next;
    out_t              res_reg,     res_next;
    logic              strobe_reg,  strobe_next;

    logic [NODE_W-1:0] step_pt;
    logic [NODE_W-1:0] step_nx;
    logic [63:0]       cr_wide;
    logic [63:0]       dl_wide;
    logic [63:0]       fw_wide;

    // Neighbor of the current hop point in the travel direction
    assign step_pt = (state_reg == ST_WALK) ? cur_reg : a_reg;
    always_comb
    begin
        if (right_reg)
        begin
            step_nx = (({1'b0, step_pt} + 1'b1) >= ring_size) ? '0 : step_pt + 1'b1;
        end
        else
        begin
            step_nx = (step_pt == '0) ? NODE_W'(ring_size - 1'b1) : step_pt - 1'b1;
        end
    end

    assign cr_wide = 64'(created);
    assign dl_wide = 64'(delivered);
    assign fw_wide = 64'(forwarded);

    // Counter bank reads and increments
    assign bank_ctl.cr_addr = head.a_node;
    assign bank_ctl.dl_addr = (head.op == OP_READ) ? head.a_node : head.b_node;
    assign bank_ctl.fw_addr = (state_reg == ST_WALK) ? cur_reg : head.a_node;
    assign bank_ctl.cr_inc  = (state_reg == ST_FIRST);
    assign bank_ctl.dl_inc  = (state_reg == ST_FIRST);
    assign bank_ctl.fw_inc  = fw_pend_reg;

    assign pop    = (state_reg == ST_IDLE) && !empty;
    assign result = res_reg;
    assign strobe = strobe_reg;

    // Sequencer next state
    always_comb
    begin
        state_next   = state_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        right_next   = right_reg;
        fw_pend_next = 1'b0;
        res_next     = res_reg;
        strobe_next  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    a_next     = head.a_node;
                    b_next     = head.b_node;
                    right_next = head.right;
                    unique case (head.op)
                        OP_ERR:
                        begin
                            res_next             = '0;
                            res_next.kind        = KIND_ERROR;
                            res_next.at_node     = head.a_node;
                            res_next.from_node   = head.a_node;
                            res_next.next_node   = head.b_node;
                            res_next.last        = 1'b1;
                            strobe_next          = 1'b1;
                        end
                        OP_READ:
                        begin
                            state_next = ST_READOUT;
                        end
                        OP_ROUTE:
                        begin
                            state_next = ST_FIRST;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_READOUT:
            begin
                res_next                 = '0;
                res_next.kind            = KIND_READOUT;
                res_next.at_node         = a_reg;
                res_next.from_node       = a_reg;
                res_next.next_node       = a_reg;
                res_next.created_total   = cr_wide[31:0];
                res_next.delivered_total = dl_wide[31:0];
                res_next.forwarded_total = fw_wide[31:0];
                res_next.last            = 1'b1;
                strobe_next              = 1'b1;
                state_next               = ST_IDLE;
            end

            ST_FIRST:
            begin
                res_next             = '0;
                res_next.at_node     = a_reg;
                res_next.from_node   = a_reg;
                res_next.going_right = right_reg;
                strobe_next          = 1'b1;
                if (a_reg == b_reg)
                begin
                    // source is the target: delivered at once
                    res_next.kind      = KIND_DELIVERED;
                    res_next.next_node = a_reg;
                    res_next.last      = 1'b1;
                    state_next         = ST_IDLE;
                end
                else
                begin
                    res_next.kind      = KIND_SENT;
                    res_next.next_node = step_nx;
                    prev_next          = a_reg;
                    cur_next           = step_nx;
                    state_next         = ST_WALK;
                end
            end

            ST_WALK:
            begin
                res_next             = '0;
                res_next.at_node     = cur_reg;
                res_next.from_node   = prev_reg;
                res_next.going_right = right_reg;
                strobe_next          = 1'b1;
                if (cur_reg == b_reg)
                begin
                    res_next.kind      = KIND_DELIVERED;
                    res_next.next_node = cur_reg;
                    res_next.last      = 1'b1;
                    state_next         = ST_IDLE;
                end
                else
                begin
                    // intermediate node: bump its forwarded count next cycle
                    res_next.kind      = KIND_FORWARDED;
                    res_next.next_node = step_nx;
                    fw_pend_next       = 1'b1;
                    prev_next          = cur_reg;
                    cur_next           = step_nx;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            a_reg       <= '0;
            b_reg       <= '0;
            cur_reg     <= '0;
            prev_reg    <= '0;
            right_reg   <= 1'b0;
            fw_pend_reg <= 1'b0;
            res_reg     <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            a_reg       <= a_next;
            b_reg       <= b_next;
            cur_reg     <= cur_next;
            prev_reg    <= prev_next;
            right_reg   <= right_next;
            fw_pend_reg <= fw_pend_next;
            res_reg     <= res_next;
            strobe_reg  <= strobe_next;
        end
    end

    // Final result of a transaction always returns the sequencer to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && res_reg.last |-> state_reg == ST_IDLE)
        else $error("last result while sequencer busy");

    // Forwarded count updates only follow a walk hop
    a_fw_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        fw_pend_reg |-> $past(state_reg) == ST_WALK && strobe_reg &&
                        res_reg.kind == KIND_FORWARDED)
        else $error("forwarded update without forwarded hop");

    // The walk always moves to a new node
    a_walk_moves: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> cur_reg != prev_reg)
        else $error("walk did not advance");

endmodule

/* rtl/core/ring_shortest_route_counter.sv */
// Top level of the ring shortest route counter.
//
// Usage:
//   Request channel: drive req and raise start; the transaction is taken at
//   a rising edge with start high and busy low. busy is high while the
//   two-entry command queue is full.
//   Result channel: each result sits on result for one cycle with strobe
//   high; the receiver cannot stall, so it must take every strobe.
//   Configuration: cfg_wr_en writes cfg_wr_data into the ring size register
//   (reset 4); write only while the block is idle.
// Sequencing:
//   With the block idle, an accepted request passes the command queue and the
//   idle state; a route then passes the first state, a readout the readout state,
//   and an error result is registered straight from idle. A route of
//   h hops produces h+1 results on consecutive cycles and occupies the walk
//   sequencer for its first state and one walk state per hop: one hop per cycle,
//   bound by the single read-modify-write port of each counter memory.
// Reset:
//   Asynchronous reset clears the queue, sequencer and counter valid bits, so
//   every counter reads zero afterwards; no clearing pass is needed.
module ring_shortest_route_counter #(
    parameter int MAX_NODES   = 64,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  rsr_pkg::in_t               req,
    input  logic                       cfg_wr_en,
    input  logic [rsr_pkg::RING_W-1:0] cfg_wr_data,
    output rsr_pkg::out_t              result,
    output logic                       strobe
);
    import rsr_pkg::*;

    logic                   fifo_full;
    logic                   fifo_empty;
    logic                   push;
    logic                   pop;
    cmd_t                   push_cmd;
    cmd_t                   head;
    logic [RING_W-1:0]      ring_size;
    bank_ctl_t              bank_ctl;
    logic [COUNT_WIDTH-1:0] created;
    logic [COUNT_WIDTH-1:0] delivered;
    logic [COUNT_WIDTH-1:0] forwarded;

    // Request check and classification
    rsr_front #(
        .MAX_NODES (MAX_NODES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fifo_full   (fifo_full),
        .push        (push),
        .push_cmd    (push_cmd),
        .ring_size   (ring_size)
    );

    // Command queue
    rsr_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (fifo_full),
        .empty    (fifo_empty),
        .head     (head)
    );

    // Walk sequencer
    rsr_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (fifo_empty),
        .head      (head),
        .pop       (pop),
        .ring_size (ring_size),
        .bank_ctl  (bank_ctl),
        .created   (created),
        .delivered (delivered),
        .forwarded (forwarded),
        .result    (result),
        .strobe    (strobe)
    );

    // Per-node counters
    rsr_counter_bank #(
        .MAX_NODES   (MAX_NODES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_bank (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (bank_ctl),
        .created   (created),
        .delivered (delivered),
        .forwarded (forwarded)
    );

endmodule
